// ===== rtl/b16c_pkg.sv =====
// ----------------------------------------------------------------------------
// b16c_pkg
// Shared types, constants and a helper function of the base16 stream codec.
// ----------------------------------------------------------------------------
package b16c_pkg;

  localparam int WRAP_WIDTH_DEFAULT = 12;
  localparam int CFG_DATA_W         = 12;
  localparam int CFG_INDEX_W        = 2;
  localparam int JOBQ_DEPTH         = 4;

  localparam logic [CFG_DATA_W-1:0] WRAP_COLS_RESET = CFG_DATA_W'(76);

  localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DROP_JUNK   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_COLS   = 2'd2;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_ODD     = 2'd2;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] BOM_BYTE0  = 8'hEF;
  localparam logic [7:0] BOM_BYTE1  = 8'hBB;
  localparam logic [7:0] BOM_BYTE2  = 8'hBF;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC_BYTE,
    JOB_EOS_ENC,
    JOB_EOS_DEC
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       nl_a;
    logic       nl_b;
    logic [7:0] value;
    logic [1:0] status;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + wide;
    end else begin
      return 8'h37 + wide;
    end
  endfunction

endpackage

// ===== rtl/b16c_if.sv =====
// ----------------------------------------------------------------------------
// b16c_if
// Channel interfaces of the base16 stream codec: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface b16c_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface b16c_result_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_value;
  logic [1:0] status;
  logic       last;
  modport source (output valid, out_kind, out_value, status, last, input ready);
  modport sink (input valid, out_kind, out_value, status, last, output ready);
endinterface

interface b16c_cfg_if import b16c_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/b16c_front.sv =====
// ----------------------------------------------------------------------------
// b16c_front
// Accepts input transactions and configuration writes, keeps the per-stream
// state and turns each item into a job for the output sequencer.
// ----------------------------------------------------------------------------
module b16c_front import b16c_pkg::*; #(
  parameter int WRAP_WIDTH = WRAP_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  b16c_item_if.sink    item,
  b16c_cfg_if.sink     cfg,
  input  logic         job_ready,
  output logic         job_valid,
  output job_t         job
);

  localparam int EXT_W = (WRAP_WIDTH > CFG_DATA_W) ? WRAP_WIDTH : CFG_DATA_W;
  localparam logic [WRAP_WIDTH-1:0] COL_MAX = '1;

  typedef enum logic [1:0] {
    BOM_START,
    BOM_EF,
    BOM_EFBB,
    BOM_DONE
  } bom_t;

  logic                  decode_mode;
  logic                  drop_junk;
  logic [WRAP_WIDTH-1:0] wrap_cols;

  logic [WRAP_WIDTH-1:0] column, column_next;
  logic                  pending_valid, pending_valid_next;
  logic [3:0]            pending_nibble, pending_nibble_next;
  bom_t                  bom_phase, bom_phase_next;
  logic                  error_seen, error_seen_next;

  logic                  accept;
  logic [EXT_W-1:0]      wrap_ext;
  logic [WRAP_WIDTH-1:0] wrap_sat;
  logic [7:0]            c;
  logic                  hex_ok;
  logic [3:0]            hex_nib;
  logic                  proceed;
  logic [WRAP_WIDTH-1:0] col_a, col_b;

  assign cfg.ready  = 1'b1;
  assign item.ready = job_ready;
  assign accept     = item.valid && job_ready;
  assign c          = item.data_byte;

  assign wrap_ext = EXT_W'(cfg.data);
  assign wrap_sat = (wrap_ext > EXT_W'(COL_MAX)) ? COL_MAX : wrap_ext[WRAP_WIDTH-1:0];

  always_comb begin
    hex_ok  = 1'b0;
    hex_nib = 4'h0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      hex_ok  = 1'b1;
      hex_nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      hex_ok  = 1'b1;
      hex_nib = 4'(c[3:0] + 4'd9);
    end else begin
      hex_ok  = 1'b0;
    end
  end

  always_comb begin
    column_next         = column;
    pending_valid_next  = pending_valid;
    pending_nibble_next = pending_nibble;
    bom_phase_next      = bom_phase;
    error_seen_next     = error_seen;
    job_valid           = 1'b0;
    job                 = '0;
    proceed             = 1'b0;
    col_a               = column;
    col_b               = column;
    if (accept) begin
      if (item.cmd == CMD_EOS) begin
        job_valid           = 1'b1;
        column_next         = '0;
        pending_valid_next  = 1'b0;
        pending_nibble_next = 4'h0;
        bom_phase_next      = BOM_START;
        error_seen_next     = 1'b0;
        if (decode_mode) begin
          job.kind = JOB_EOS_DEC;
          if (error_seen ||
              ((bom_phase == BOM_EF || bom_phase == BOM_EFBB) && !drop_junk)) begin
            job.status = ST_INVALID;
          end else if (pending_valid) begin
            job.status = ST_ODD;
          end else begin
            job.status = ST_OK;
          end
        end else begin
          job.kind = JOB_EOS_ENC;
        end
      end else if (decode_mode) begin
        if (!error_seen) begin
          unique case (bom_phase)
            BOM_START: begin
              if (c == BOM_BYTE0) begin
                bom_phase_next = BOM_EF;
              end else begin
                bom_phase_next = BOM_DONE;
                proceed        = 1'b1;
              end
            end
            BOM_EF, BOM_EFBB: begin
              if (bom_phase == BOM_EF && c == BOM_BYTE1) begin
                bom_phase_next = BOM_EFBB;
              end else if (bom_phase == BOM_EFBB && c == BOM_BYTE2) begin
                bom_phase_next = BOM_DONE;
              end else begin
                bom_phase_next = BOM_DONE;
                if (drop_junk) begin
                  proceed = 1'b1;
                end else begin
                  error_seen_next = 1'b1;
                end
              end
            end
            BOM_DONE: proceed = 1'b1;
          endcase
          if (proceed && c != CHAR_NL && c != CHAR_CR && c != CHAR_TAB &&
              c != CHAR_SPACE) begin
            if (!hex_ok) begin
              if (!drop_junk) begin
                error_seen_next = 1'b1;
              end
            end else if (!pending_valid) begin
              pending_valid_next  = 1'b1;
              pending_nibble_next = hex_nib;
            end else begin
              job_valid           = 1'b1;
              job.kind            = JOB_DEC_BYTE;
              job.value           = {pending_nibble, hex_nib};
              pending_valid_next  = 1'b0;
              pending_nibble_next = 4'h0;
            end
          end
        end
      end else begin
        job_valid = 1'b1;
        job.kind  = JOB_ENC;
        job.value = c;
        if (wrap_cols != '0 && column >= wrap_cols) begin
          job.nl_a = 1'b1;
          col_a    = '0;
        end
        col_b = (col_a == COL_MAX) ? col_a : col_a + 1'b1;
        if (wrap_cols != '0 && col_b >= wrap_cols) begin
          job.nl_b = 1'b1;
          col_b    = '0;
        end
        column_next = (col_b == COL_MAX) ? col_b : col_b + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode    <= 1'b0;
      drop_junk      <= 1'b0;
      wrap_cols      <= (EXT_W'(WRAP_COLS_RESET) > EXT_W'(COL_MAX)) ?
                        COL_MAX : WRAP_WIDTH'(WRAP_COLS_RESET);
      column         <= '0;
      pending_valid  <= 1'b0;
      pending_nibble <= 4'h0;
      bom_phase      <= BOM_START;
      error_seen     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_DECODE_MODE: decode_mode <= cfg.data[0];
          REG_DROP_JUNK:   drop_junk   <= cfg.data[0];
          REG_WRAP_COLS:   wrap_cols   <= wrap_sat;
          default: ;
        endcase
      end
      column         <= column_next;
      pending_valid  <= pending_valid_next;
      pending_nibble <= pending_nibble_next;
      bom_phase      <= bom_phase_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule

// ===== rtl/b16c_queue.sv =====
// ----------------------------------------------------------------------------
// b16c_queue
// Short job queue that decouples the item front end from the output
// sequencer.
// ----------------------------------------------------------------------------
module b16c_queue import b16c_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOBQ_DEPTH - 1);

  job_t             slots [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(JOBQ_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = pop_valid ? slots[rd_ptr] : '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b16c_back.sv =====
// ----------------------------------------------------------------------------
// b16c_back
// Output sequencer: walks the result slots of the job at the queue head and
// presents them one per transaction through the output register.
// ----------------------------------------------------------------------------
module b16c_back import b16c_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  input  job_t         job,
  output logic         job_pop,
  b16c_result_if.source result
);

  logic [1:0] phase;
  logic [3:0] mask, avail;
  logic [1:0] sel;
  logic       take;
  logic       sel_kind;
  logic [7:0] sel_value;
  logic [1:0] sel_status;

  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_value;
  logic [1:0] out_status;
  logic       out_last;

  // Slot 0: leading newline, 1: first character, 2: second newline,
  // 3: final result of the job (always present).
  always_comb begin
    unique case (job.kind)
      JOB_ENC:      mask = {1'b1, job.nl_b, 1'b1, job.nl_a};
      JOB_EOS_ENC:  mask = 4'b1100;
      JOB_DEC_BYTE: mask = 4'b1000;
      JOB_EOS_DEC:  mask = 4'b1000;
    endcase
  end

  assign avail = mask & (4'b1111 << phase);

  always_comb begin
    priority if (avail[0]) begin
      sel = 2'd0;
    end else if (avail[1]) begin
      sel = 2'd1;
    end else if (avail[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  always_comb begin
    sel_kind   = KIND_DATA;
    sel_value  = CHAR_NL;
    sel_status = ST_OK;
    unique case (job.kind)
      JOB_ENC: begin
        if (sel == 2'd1) begin
          sel_value = hex_char(job.value[7:4]);
        end else if (sel == 2'd3) begin
          sel_value = hex_char(job.value[3:0]);
        end
      end
      JOB_DEC_BYTE: sel_value = job.value;
      JOB_EOS_ENC: begin
        if (sel == 2'd3) begin
          sel_kind  = KIND_STATUS;
          sel_value = 8'h00;
        end
      end
      JOB_EOS_DEC: begin
        sel_kind   = KIND_STATUS;
        sel_value  = 8'h00;
        sel_status = job.status;
      end
    endcase
  end

  assign take    = job_valid && (!out_valid || result.ready);
  assign job_pop = take && (sel == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        phase     <= (sel == 2'd3) ? 2'd0 : sel + 2'd1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind   <= sel_kind;
      out_value  <= sel_value;
      out_status <= sel_status;
      out_last   <= (sel == 2'd3);
    end
  end

  assign result.valid     = out_valid;
  assign result.out_kind  = out_kind;
  assign result.out_value = out_value;
  assign result.status    = out_status;
  assign result.last      = out_last;

  a_status_item_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS |-> out_value == 8'h00 && out_last)
    else $error("status item with nonzero value or not last");

  a_data_item_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DATA |-> out_status == ST_OK)
    else $error("data item carries a status code");

  a_phase_restart: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> phase == 2'd0)
    else $error("slot phase not restarted after job completion");

endmodule

// ===== rtl/base16_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base16_stream_codec
// Streaming hex encoder and decoder with line wrapping, byte order mark
// skipping and end-of-stream status reporting.
// ----------------------------------------------------------------------------
// Throughput: one result per cycle while the receiver is ready, set by the single output
// register; an encoded byte yields two results (three or four with newlines), a
// decoded byte one result.
// Reset (synchronous): configuration returns to encode, strict, wrap 76;
// stream state is cleared and the job queue is emptied.
module base16_stream_codec import b16c_pkg::*; #(
  parameter int WRAP_WIDTH = WRAP_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  b16c_item_if.sink     item,
  b16c_result_if.source result,
  b16c_cfg_if.sink      cfg
);

  logic front_valid, front_ready;
  job_t front_job;
  logic head_valid, head_pop;
  job_t head_job;

  b16c_front #(
    .WRAP_WIDTH(WRAP_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg),
    .job_ready (front_ready),
    .job_valid (front_valid),
    .job       (front_job)
  );

  b16c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_job    (head_job)
  );

  b16c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (head_pop),
    .result    (result)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the base16 stream codec. Random and directed
// byte streams are sent through both modes. Every accepted transaction is run
// through a behavioural model of the codec. Each result is checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
  import b16c_pkg::*;

  localparam int WRAP_W            = WRAP_WIDTH_DEFAULT;
  localparam int COL_MAX           = (1 << WRAP_W) - 1;
  localparam int SETTLE_CYCLES     = 2 * JOBQ_DEPTH + 4;
  localparam int RANDOM_ITEMS      = 300;
  localparam int LONG_STALL_CYCLES = 80;
  localparam int LONG_LINE_BYTES   = 20;
  localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";

  localparam logic [1:0] BOM_START   = 2'd0;
  localparam logic [1:0] BOM_SEEN_EF = 2'd1;
  localparam logic [1:0] BOM_SEEN_BB = 2'd2;
  localparam logic [1:0] BOM_PASSED  = 2'd3;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_THREE_OF_FOUR,
    RX_SPARSE
  } rx_mode_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } hex_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_value;
    logic [1:0] status;
    logic       last;
  } hex_out_t;

  logic clk;
  logic rst;

  b16c_item_if   item_ch ();
  b16c_result_if res_ch ();
  b16c_cfg_if    cfg_ch ();

  base16_stream_codec #(.WRAP_WIDTH(WRAP_W)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  hex_item_t pending_items[$];
  hex_out_t  hex_out_q[$];
  hex_out_t  step_buf[0:3];
  int        step_cnt;

  int items_queued    = 0;
  int items_accepted  = 0;
  int results_seen    = 0;
  int error_count     = 0;
  int reg_writes      = 0;
  int eos_marks       = 0;
  int stall_req_seq   = 0;
  int stall_done_seq  = 0;
  logic item_taken;

  logic              dec_mode;
  logic              ign_garbage;
  logic [WRAP_W-1:0] wrap_lim;
  logic [WRAP_W-1:0] col_cnt;
  logic              nib_pending;
  logic [3:0]        nib_high;
  logic [1:0]        bom_ph;
  logic              err_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL base16_stream_codec");
    $finish;
  end

  function automatic void restart_stream();
    col_cnt     = '0;
    nib_pending = 1'b0;
    nib_high    = 4'h0;
    bom_ph      = BOM_START;
    err_seen    = 1'b0;
  endfunction

  function automatic void stage(input logic kind, input logic [7:0] value,
                                input logic [1:0] st);
    hex_out_t r;
    r.out_kind  = kind;
    r.out_value = value;
    r.status    = st;
    r.last      = 1'b0;
    step_buf[step_cnt] = r;
    step_cnt++;
  endfunction

  function automatic void put_hex_char(input logic [3:0] nib);
    if (wrap_lim != 0 && col_cnt >= wrap_lim) begin
      stage(KIND_DATA, CHAR_NL, ST_OK);
      col_cnt = '0;
    end
    stage(KIND_DATA, HEX_DIGITS[8*(15 - nib) +: 8], ST_OK);
    if (col_cnt < COL_MAX) col_cnt++;
  endfunction

  function automatic void hex_codec_step(input hex_item_t it);
    hex_out_t   r;
    logic [7:0] b;
    logic       skip;
    logic       is_hex;
    logic [3:0] nib;
    logic [1:0] st;
    b        = it.data_byte;
    skip     = 1'b0;
    is_hex   = 1'b0;
    nib      = 4'h0;
    step_cnt = 0;
    if (it.cmd == CMD_DATA) begin
      if (!dec_mode) begin
        put_hex_char(b[7:4]);
        put_hex_char(b[3:0]);
      end else if (!err_seen) begin
        if (bom_ph == BOM_START) begin
          if (b == BOM_BYTE0) begin
            bom_ph = BOM_SEEN_EF;
            skip   = 1'b1;
          end else begin
            bom_ph = BOM_PASSED;
          end
        end else if (bom_ph == BOM_SEEN_EF && b == BOM_BYTE1) begin
          bom_ph = BOM_SEEN_BB;
          skip   = 1'b1;
        end else if (bom_ph == BOM_SEEN_BB && b == BOM_BYTE2) begin
          bom_ph = BOM_PASSED;
          skip   = 1'b1;
        end else if (bom_ph != BOM_PASSED) begin
          bom_ph = BOM_PASSED;
          if (!ign_garbage) begin
            err_seen = 1'b1;
            skip     = 1'b1;
          end
        end
        if (!skip && b != CHAR_NL && b != CHAR_CR && b != CHAR_TAB && b != CHAR_SPACE) begin
          if (b >= "0" && b <= "9") begin
            is_hex = 1'b1;
            nib    = 4'(b - "0");
          end else if (b >= "A" && b <= "F") begin
            is_hex = 1'b1;
            nib    = 4'(b - "A" + 8'd10);
          end else if (b >= "a" && b <= "f") begin
            is_hex = 1'b1;
            nib    = 4'(b - "a" + 8'd10);
          end
          if (!is_hex) begin
            if (!ign_garbage) err_seen = 1'b1;
          end else if (!nib_pending) begin
            nib_pending = 1'b1;
            nib_high    = nib;
          end else begin
            stage(KIND_DATA, {nib_high, nib}, ST_OK);
            nib_pending = 1'b0;
            nib_high    = 4'h0;
          end
        end
      end
    end else begin
      if (dec_mode) begin
        if ((bom_ph == BOM_SEEN_EF || bom_ph == BOM_SEEN_BB) && !ign_garbage) err_seen = 1'b1;
        if (err_seen) st = ST_INVALID;
        else if (nib_pending) st = ST_ODD;
        else st = ST_OK;
        stage(KIND_STATUS, 8'h00, st);
      end else begin
        stage(KIND_DATA, CHAR_NL, ST_OK);
        stage(KIND_STATUS, 8'h00, ST_OK);
      end
      restart_stream();
    end
    for (int i = 0; i < step_cnt; i++) begin
      r      = step_buf[i];
      r.last = (i == step_cnt - 1);
      hex_out_q.push_back(r);
    end
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    hex_out_t got;
    hex_out_t want;
    if (rst) begin
      item_taken  <= 1'b0;
      dec_mode    = 1'b0;
      ign_garbage = 1'b0;
      if (int'(WRAP_COLS_RESET) > COL_MAX) wrap_lim = WRAP_W'(COL_MAX);
      else wrap_lim = WRAP_W'(WRAP_COLS_RESET);
      restart_stream();
    end else begin
      item_taken <= item_ch.valid && item_ch.ready;
      if (item_ch.valid && item_ch.ready) begin
        items_accepted++;
        hex_codec_step('{cmd: item_ch.cmd, data_byte: item_ch.data_byte});
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          REG_DECODE_MODE: dec_mode = cfg_ch.data[0];
          REG_DROP_JUNK:   ign_garbage = cfg_ch.data[0];
          REG_WRAP_COLS: begin
            if (int'(cfg_ch.data) > COL_MAX) wrap_lim = WRAP_W'(COL_MAX);
            else wrap_lim = WRAP_W'(cfg_ch.data);
          end
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        got = '{out_kind: res_ch.out_kind, out_value: res_ch.out_value,
                status: res_ch.status, last: res_ch.last};
        if (hex_out_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual 'h%0h", $time, got);
        end else begin
          want = hex_out_q.pop_front();
          check_field("out_kind", int'(want.out_kind), int'(got.out_kind));
          check_field("out_value", int'(want.out_value), int'(got.out_value));
          check_field("status", int'(want.status), int'(got.status));
          check_field("last", int'(want.last), int'(got.last));
        end
      end
    end
  end

  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    hex_item_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_taken) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        item_ch.valid     <= 1'b0;
        item_ch.cmd       <= 1'($urandom_range(0, 1));
        item_ch.data_byte <= 8'($urandom_range(0, 255));
      end else begin
        nxt = pending_items.pop_front();
        item_ch.valid     <= 1'b1;
        item_ch.cmd       <= nxt.cmd;
        item_ch.data_byte <= nxt.data_byte;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 7))
            0, 1, 2, 3: gap_left = 0;
            4, 5:       gap_left = $urandom_range(1, 3);
            6:          gap_left = $urandom_range(4, 12);
            default:    gap_left = $urandom_range(20, 40);
          endcase
        end
      end
    end
  end

  int       rx_cycle  = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode   = RX_ALWAYS;

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (stall_req_seq != stall_done_seq) begin
        stall_done_seq++;
        hold_left = LONG_STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:        res_ch.ready <= 1'b1;
          RX_COIN:          res_ch.ready <= 1'($urandom_range(0, 1));
          RX_THREE_OF_FOUR: res_ch.ready <= (rx_cycle % 4 != 3);
          default:          res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic push_item(input logic cmd, input logic [7:0] data);
    pending_items.push_back('{cmd: cmd, data_byte: data});
    items_queued++;
    if (cmd == CMD_EOS) eos_marks++;
  endtask

  task automatic push_bytes(input logic [8*16-1:0] text, input int n);
    for (int i = n - 1; i >= 0; i--) push_item(CMD_DATA, text[8*i +: 8]);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_config(input logic dec, input logic ign, input int wrap);
    write_reg(REG_DECODE_MODE, int'(dec));
    write_reg(REG_DROP_JUNK, int'(ign));
    write_reg(REG_WRAP_COLS, wrap);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || hex_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic gen_encode_stream();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       push_item(CMD_DATA, 8'h00);
        1:       push_item(CMD_DATA, 8'hFF);
        default: push_item(CMD_DATA, 8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 3) != 0) push_item(CMD_EOS, 8'($urandom_range(0, 255)));
  endtask

  task automatic gen_decode_stream();
    int         n;
    int         v;
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      0, 1, 2: push_bytes(128'({BOM_BYTE0, BOM_BYTE1, BOM_BYTE2}), 3);
      3: begin
        push_item(CMD_DATA, BOM_BYTE0);
        if ($urandom_range(0, 1) != 0) push_item(CMD_DATA, BOM_BYTE1);
      end
      default: ;
    endcase
    n = 2 * $urandom_range(0, 8);
    if ($urandom_range(0, 7) == 0) n++;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       push_item(CMD_DATA, CHAR_NL);
          1:       push_item(CMD_DATA, CHAR_CR);
          2:       push_item(CMD_DATA, CHAR_TAB);
          default: push_item(CMD_DATA, CHAR_SPACE);
        endcase
      end
      v = $urandom_range(0, 15);
      if (v < 10) ch = 8'("0" + v);
      else if ($urandom_range(0, 1) != 0) ch = 8'("A" + v - 10);
      else ch = 8'("a" + v - 10);
      push_item(CMD_DATA, ch);
      if ($urandom_range(0, 19) == 0) push_item(CMD_DATA, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 5) != 0) push_item(CMD_EOS, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    int first_random;
    int streams;
    int wrap;
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.cmd       = CMD_DATA;
    item_ch.data_byte = 8'h00;
    res_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_DECODE_MODE;
    cfg_ch.data       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_config(1'b0, 1'b0, 3);
    push_item(CMD_DATA, 8'h00);
    push_item(CMD_DATA, 8'hFF);
    push_item(CMD_EOS, 8'h00);
    wait_idle();

    @(posedge clk);
    push_item(CMD_DATA, 8'h3C);
    wait_idle();
    write_reg(REG_DECODE_MODE, 1);
    @(posedge clk);
    push_item(CMD_DATA, "4");
    wait_idle();
    write_reg(REG_DECODE_MODE, 0);
    @(posedge clk);
    push_item(CMD_DATA, 8'h7E);
    push_item(CMD_EOS, 8'hFF);
    wait_idle();

    apply_config(1'b1, 1'b0, 0);
    push_bytes(128'({BOM_BYTE0, BOM_BYTE1, BOM_BYTE2, "a", CHAR_SPACE, "F", CHAR_TAB, "0",
                     CHAR_CR, "9", CHAR_NL}), 11);
    push_item(CMD_EOS, 8'h00);
    push_bytes(128'("G1"), 2);
    push_item(CMD_EOS, 8'h00);
    wait_idle();

    write_reg(REG_DROP_JUNK, 1);
    @(posedge clk);
    push_bytes(128'({BOM_BYTE0, "4x1"}), 4);
    push_item(CMD_EOS, 8'h00);
    wait_idle();

    first_random = items_queued;
    phase = 0;
    while (items_queued - first_random < RANDOM_ITEMS) begin
      phase++;
      case ($urandom_range(0, 5))
        0:       wrap = 0;
        1:       wrap = 1;
        2:       wrap = 4095;
        3:       wrap = 76;
        default: wrap = $urandom_range(2, 40);
      endcase
      apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), wrap);
      streams = (phase == 3) ? 6 : $urandom_range(1, 3);
      for (int s = 0; s < streams; s++) begin
        if (dec_mode) gen_decode_stream();
        else gen_encode_stream();
        if (phase == 5 && s == 0) begin
          wait_idle();
          @(posedge clk);
        end
      end
      if (phase == 3) begin
        for (int i = 0; i < 30; i++) push_item(CMD_DATA, 8'($urandom_range(0, 255)));
        stall_req_seq <= stall_req_seq + 1;
      end
      wait_idle();
    end

    // Build a long line with wrapping off, then turn on a short wrap width so
    // that the column count already past it forces a newline at once.
    apply_config(1'b0, 1'b0, 0);
    for (int i = 0; i < LONG_LINE_BYTES; i++) push_item(CMD_DATA, 8'($urandom_range(0, 255)));
    wait_idle();
    write_reg(REG_WRAP_COLS, 8);
    @(posedge clk);
    push_item(CMD_DATA, 8'hA5);
    push_item(CMD_EOS, 8'h00);
    wait_idle();

    $display("Sent %0d transactions in %0d random phases, %0d end-of-stream marks.",
             items_accepted, phase, eos_marks);
    $display("Checked %0d results across %0d register writes.", results_seen, reg_writes);
    if (error_count == 0) begin
      $display("PASS base16_stream_codec");
    end else begin
      $display("FAIL base16_stream_codec");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/b16c_pkg.sv
rtl/b16c_if.sv
rtl/b16c_front.sv
rtl/b16c_queue.sv
rtl/b16c_back.sv
rtl/base16_stream_codec.sv
sim/tb.sv
